// ----- hdl/hsqrt_pkg.sv -----
package hsqrt_pkg;

  // Default fixed-point format of the estimates.
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned DATA_WIDTH    = 32;

  // Widths of the fixed fields.
  localparam int unsigned RADICAND_W  = 32;
  localparam int unsigned TOLERANCE_W = 16;
  localparam int unsigned LIMIT_W     = 8;
  localparam int unsigned GUESS_W     = 32;
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RADICAND  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT     = 2'd2;

  // Register reset values: radicand 5.0 in Q16.16, tolerance 2 LSBs, limit 100.
  localparam logic [RADICAND_W-1:0]  RADICAND_RST  = 32'd327680;
  localparam logic [TOLERANCE_W-1:0] TOLERANCE_RST = 16'd2;
  localparam logic [LIMIT_W-1:0]     LIMIT_RST     = 8'd100;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_CONVERGED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LIMIT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_DIV  = 2'd2;

endpackage

// ----- hdl/hsqrt_div.sv -----
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
module hsqrt_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] acc_q, acc_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  // The partial remainder takes the next numerator bit; the quotient bit
  // shifts into the low end of the same register.
  assign rem_sh  = {rem_q, acc_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = !rem_sub[DEN_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W - 1);
      acc_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      acc_d = {acc_q[NUM_W-2:0], fits};
      rem_d = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

// ----- hdl/heron_square_root_iteration.sv -----
// Each update step checks the limit, divides the radicand (Q16.16 by default)
// by the estimate magnitude, saturates the quotient, averages and tests.
// Throughput: one item at a time; busy stays high until the result strobe.
// The quotient divider, one bit per cycle, sets the length of every step.
// Reset (rst_ni low, asynchronous) returns to idle and loads the register
// defaults: radicand 5.0, tolerance 2 LSBs, limit 100. Results cannot be stalled.
module heron_square_root_iteration #(
  parameter int unsigned FRACTION_BITS = hsqrt_pkg::FRACTION_BITS,
  parameter int unsigned DATA_WIDTH    = hsqrt_pkg::DATA_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hsqrt_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [hsqrt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Command side.
  input  logic                                start,
  output logic                                busy,
  input  logic signed [hsqrt_pkg::GUESS_W-1:0] initial_guess_i,
  // Result side.
  output logic                                result_valid_o,
  output logic signed [hsqrt_pkg::ROOT_W-1:0] root_o,
  output logic [hsqrt_pkg::LIMIT_W-1:0]       iterations_used_o,
  output logic [hsqrt_pkg::STATUS_W-1:0]      status_o
);

  localparam int unsigned DW   = DATA_WIDTH;
  // Numerator of each division: the radicand shifted up by the fraction bits.
  localparam int unsigned QW   = hsqrt_pkg::RADICAND_W + FRACTION_BITS;
  // Width that holds both the raw quotient and the estimate limits.
  localparam int unsigned CMPW = ((QW > DW) ? QW : DW) + 1;
  // Width that holds both the incoming guess and an estimate.
  localparam int unsigned GW   = (DW > hsqrt_pkg::GUESS_W) ? DW : hsqrt_pkg::GUESS_W;

  localparam logic [CMPW-1:0] Q_POS_MAX = (CMPW'(1) << (DW - 1)) - CMPW'(1);
  localparam logic [CMPW-1:0] Q_NEG_MAG = CMPW'(1) << (DW - 1);
  localparam logic [GW-1:0]   G_MAX     = (GW'(1) << (DW - 1)) - GW'(1);
  localparam logic [GW-1:0]   G_MIN     = ~G_MAX;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SAT   = 3'd3;
  localparam logic [2:0] S_AVG   = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;

  logic [2:0] state_q, state_d;

  // Configuration registers. The user must write them only while the block is
  // idle; the block does not enforce this, and the channel is always ready.
  logic [hsqrt_pkg::RADICAND_W-1:0]  radicand_q;
  logic [hsqrt_pkg::TOLERANCE_W-1:0] tolerance_q;
  logic [hsqrt_pkg::LIMIT_W-1:0]     limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radicand_q  <= hsqrt_pkg::RADICAND_RST;
      tolerance_q <= hsqrt_pkg::TOLERANCE_RST;
      limit_q     <= hsqrt_pkg::LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hsqrt_pkg::REG_RADICAND:  radicand_q  <= cfg_data_i;
        hsqrt_pkg::REG_TOLERANCE: tolerance_q <= cfg_data_i[hsqrt_pkg::TOLERANCE_W-1:0];
        hsqrt_pkg::REG_LIMIT:     limit_q     <= cfg_data_i[hsqrt_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers.
  logic signed [DW-1:0]         est_q, est_d;
  logic signed [DW-1:0]         quo_q, quo_d;
  logic signed [DW-1:0]         next_q, next_d;
  logic [hsqrt_pkg::LIMIT_W-1:0] steps_q, steps_d;

  // Result registers; the strobe is high for one cycle per transaction.
  logic                                valid_q, valid_d;
  logic signed [hsqrt_pkg::ROOT_W-1:0] root_q, root_d;
  logic [hsqrt_pkg::LIMIT_W-1:0]       iters_q, iters_d;
  logic [hsqrt_pkg::STATUS_W-1:0]      status_q, status_d;

  // The starting estimate saturates into the estimate range when the
  // estimate is narrower than the guess.
  logic signed [GW-1:0] guess_ext;
  logic signed [DW-1:0] guess_clamped;

  always_comb begin
    guess_ext = GW'(initial_guess_i);
    priority if (guess_ext > $signed(G_MAX)) begin
      guess_clamped = G_MAX[DW-1:0];
    end else if (guess_ext < $signed(G_MIN)) begin
      guess_clamped = G_MIN[DW-1:0];
    end else begin
      guess_clamped = guess_ext[DW-1:0];
    end
  end

  // The divider works on the magnitude of the estimate. The most negative
  // estimate gives a magnitude that still fits DW unsigned bits.
  logic          div_start;
  logic          div_done;
  logic [QW-1:0] div_quot;
  logic [DW-1:0] est_mag;
  logic [QW-1:0] div_num;

  assign est_mag = est_q[DW-1] ? DW'(-est_q) : DW'(est_q);
  assign div_num = {radicand_q, {FRACTION_BITS{1'b0}}};

  hsqrt_div #(
    .NUM_W(QW),
    .DEN_W(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (est_mag),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Quotient saturation: the positive side stops at the largest estimate,
  // the negative side at the most negative one.
  logic [CMPW-1:0] quot_ext;
  logic [CMPW-1:0] quot_neg_mag;
  logic signed [DW-1:0] quot_sat;

  always_comb begin
    quot_ext     = CMPW'(div_quot);
    quot_neg_mag = (quot_ext > Q_NEG_MAG) ? Q_NEG_MAG : quot_ext;
    if (est_q[DW-1]) begin
      quot_sat = -$signed(quot_neg_mag[DW-1:0]);
    end else begin
      quot_sat = (quot_ext > Q_POS_MAX) ? $signed(Q_POS_MAX[DW-1:0])
                                        : $signed(quot_ext[DW-1:0]);
    end
  end

  // Halving rounds toward minus infinity on the exact one-bit-wider sum.
  logic signed [DW:0] avg_sum;
  assign avg_sum = {est_q[DW-1], est_q} + {quo_q[DW-1], quo_q};

  // Absolute change between successive estimates, compared to the tolerance.
  logic signed [DW:0] chg;
  logic [DW:0]        chg_abs;
  logic               converged;

  assign chg       = {next_q[DW-1], next_q} - {est_q[DW-1], est_q};
  assign chg_abs   = chg[DW] ? (DW+1)'(-chg) : (DW+1)'(chg);
  assign converged = chg_abs < (DW+1)'(tolerance_q);

  // Root output: the estimate sign-extended or cut to the port width.
  logic signed [GW-1:0] est_ext;
  assign est_ext = GW'(est_q);

  always_comb begin
    state_d   = state_q;
    est_d     = est_q;
    quo_d     = quo_q;
    next_d    = next_q;
    steps_d   = steps_q;
    valid_d   = 1'b0;
    root_d    = root_q;
    iters_d   = iters_q;
    status_d  = status_q;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          est_d   = guess_clamped;
          steps_d = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // The limit is tested before the zero estimate, so a limit of zero
        // reports the starting estimate with the limit status.
        priority if (steps_q >= limit_q) begin
          valid_d  = 1'b1;
          root_d   = est_ext[hsqrt_pkg::ROOT_W-1:0];
          iters_d  = steps_q;
          status_d = hsqrt_pkg::ST_LIMIT;
          state_d  = S_IDLE;
        end else if (est_q == '0) begin
          valid_d  = 1'b1;
          root_d   = '0;
          iters_d  = steps_q;
          status_d = hsqrt_pkg::ST_ZERO_DIV;
          state_d  = S_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        quo_d   = quot_sat;
        state_d = S_AVG;
      end
      S_AVG: begin
        next_d  = avg_sum[DW:1];
        steps_d = steps_q + hsqrt_pkg::LIMIT_W'(1);
        state_d = S_TEST;
      end
      S_TEST: begin
        est_d = next_q;
        if (converged) begin
          valid_d  = 1'b1;
          root_d   = hsqrt_pkg::ROOT_W'(next_q);
          iters_d  = steps_q;
          status_d = hsqrt_pkg::ST_CONVERGED;
          state_d  = S_IDLE;
        end else begin
          state_d = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    est_q    <= est_d;
    quo_q    <= quo_d;
    next_q   <= next_d;
    steps_q  <= steps_d;
    root_q   <= root_d;
    iters_q  <= iters_d;
    status_q <= status_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign result_valid_o    = valid_q;
  assign root_o            = root_q;
  assign iterations_used_o = iters_q;
  assign status_o          = status_q;

endmodule

// ----- tb/heron_square_root_iteration_test.sv -----
// Self-checking bench for the fixed-point Heron square-root block.
// A behavioral predictor computes every result before an item is sent and
// queues it once the item is accepted, and a negedge monitor compares each
// result strobe with the oldest prediction still pending.
module heron_square_root_iteration_test;
  import hsqrt_pkg::*;

  // Index that maps to no register; a write to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

  // Largest magnitude an estimate can hold. A negative quotient may reach it,
  // while a positive quotient stops one LSB short of it.
  localparam longint EST_SPAN = longint'(1) << (DATA_WIDTH - 1);

  // The slowest item makes 255 steps. Going quiet for much longer than such
  // an item runs can only mean that the block has hung.
  localparam int unsigned WATCHDOG_CYCLES = 60000;

  // The most mismatch lines that get printed. Past that they are only counted.
  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    logic signed [ROOT_W-1:0] root;
    logic [LIMIT_W-1:0]       steps;
    logic [STATUS_W-1:0]      status;
  } root_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_INDEX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;
  logic                       start;
  logic                       busy;
  logic signed [GUESS_W-1:0]  initial_guess_i;
  logic                       result_valid_o;
  logic signed [ROOT_W-1:0]   root_o;
  logic [LIMIT_W-1:0]         iterations_used_o;
  logic [STATUS_W-1:0]        status_o;

  // Local copy of the registers. It is updated on every write the bench makes.
  logic [RADICAND_W-1:0]  cur_radicand;
  logic [TOLERANCE_W-1:0] cur_tolerance;
  logic [LIMIT_W-1:0]     cur_limit;

  root_result_t pending_roots[$];
  int unsigned  mismatch_count;
  bit           gaps_on;

  heron_square_root_iteration u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .start             (start),
    .busy              (busy),
    .initial_guess_i   (initial_guess_i),
    .result_valid_o    (result_valid_o),
    .root_o            (root_o),
    .iterations_used_o (iterations_used_o),
    .status_o          (status_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Runs the iteration exactly as the block should. Estimates are kept in
  // 64-bit signed integers, so the sum of the estimate and the quotient
  // cannot overflow, and an arithmetic shift rounds it toward minus infinity.
  function automatic root_result_t predict_root(input logic signed [GUESS_W-1:0] guess);
    longint       est;
    longint       quo;
    longint       nxt;
    longint       delta;
    longint       mag;
    longint       num;
    int unsigned  steps;
    root_result_t res;
    est        = guess;
    // A guess wider than an estimate saturates into the estimate range.
    if (est > EST_SPAN - 1) est = EST_SPAN - 1;
    if (est < -EST_SPAN) est = -EST_SPAN;
    num        = longint'({32'd0, cur_radicand}) << FRACTION_BITS;
    steps      = 0;
    res.status = ST_LIMIT;
    while (steps < cur_limit) begin
      // A zero estimate cannot be divided by, so the step is not made.
      if (est == 0) begin
        res.status = ST_ZERO_DIV;
        break;
      end
      mag = (est < 0) ? -est : est;
      quo = num / mag;
      // The quotient takes the sign of the estimate and saturates to the
      // range of an estimate.
      if (est < 0) begin
        if (quo > EST_SPAN) quo = EST_SPAN;
        quo = -quo;
      end else if (quo > EST_SPAN - 1) begin
        quo = EST_SPAN - 1;
      end
      nxt   = (est + quo) >>> 1;
      steps = steps + 1;
      delta = nxt - est;
      if (delta < 0) delta = -delta;
      est = nxt;
      // The converging step is counted and its estimate is returned.
      if (delta < longint'(cur_tolerance)) begin
        res.status = ST_CONVERGED;
        break;
      end
    end
    res.root  = est[ROOT_W-1:0];
    res.steps = steps[LIMIT_W-1:0];
    return res;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] error: %s", $realtime, what);
    mismatch_count++;
  endtask

  // A transaction on either channel is sampled at the falling edge. The
  // signals are stable there, and they are what the next rising edge accepts.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (index)
      REG_RADICAND:  cur_radicand  = data[RADICAND_W-1:0];
      REG_TOLERANCE: cur_tolerance = data[TOLERANCE_W-1:0];
      REG_LIMIT:     cur_limit     = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [RADICAND_W-1:0] radicand,
                               input logic [TOLERANCE_W-1:0] tolerance,
                               input logic [LIMIT_W-1:0] limit);
    write_register(REG_RADICAND, radicand);
    write_register(REG_TOLERANCE, {16'd0, tolerance});
    write_register(REG_LIMIT, {24'd0, limit});
  endtask

  // Sends one starting estimate. Start stays high while the block is busy
  // with the previous item. When gaps are on, a random idle burst may come
  // first, so the idle time falls on every part of an item's run.
  task automatic send_guess(input logic signed [GUESS_W-1:0] guess);
    root_result_t predicted;
    predicted = predict_root(guess);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    @(posedge clk_i);
    start           <= 1'b1;
    initial_guess_i <= guess;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    pending_roots.push_back(predicted);
    start <= 1'b0;
  endtask

  // Registers may only change while the block is idle. Every item gives a
  // result, so an empty queue means that nothing is left in flight.
  task automatic wait_drained();
    while (pending_roots.size() != 0) @(posedge clk_i);
  endtask

  // Result checker. The receiver cannot stall, so every strobe is a transaction.
  always @(negedge clk_i) begin
    root_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_roots.size() == 0) begin
        note_mismatch("result strobe with no item outstanding");
      end else begin
        want = pending_roots.pop_front();
        if (root_o !== want.root)
          note_mismatch($sformatf("root %h, expected %h", root_o, want.root));
        if (iterations_used_o !== want.steps)
          note_mismatch($sformatf("iterations_used %0d, expected %0d",
                                  iterations_used_o, want.steps));
        if (status_o !== want.status)
          note_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
      end
    end
  end

  // Watchdog. It counts the cycles in which no transaction of any kind happens.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(negedge clk_i);
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("heron_square_root_iteration: mismatch");
    $finish;
  end

  // Reset defaults: roots of 5.0 from positive and negative guesses, the
  // extreme guesses, and guesses of a single LSB.
  task automatic test_default_registers();
    send_guess(32'sh0001_0000);
    send_guess(32'sh0002_0000);
    send_guess(-32'sh0002_0000);
    send_guess(32'sh7FFF_FFFF);
    send_guess(32'sh8000_0000);
    send_guess(32'sh0000_0001);
    send_guess(-32'sh0000_0001);
  endtask

  // Zero divisor. First the starting guess is zero. Then, with a zero
  // radicand, the estimate halves from 1 LSB down to zero and the next
  // step hits the zero.
  task automatic test_zero_divisor();
    send_guess(32'sh0);
    wait_drained();
    set_registers(32'd0, 16'd1, LIMIT_RST);
    send_guess(32'sh1);
    wait_drained();
  endtask

  // Registers at their extremes. A huge radicand over a tiny estimate makes
  // the quotient saturate on both sides. A limit of one step stops at once.
  task automatic test_register_extremes();
    set_registers(32'hFFFF_FFFF, 16'hFFFF, 8'd255);
    send_guess(32'sh1);
    send_guess(-32'sh1);
    send_guess(32'sh7FFF_FFFF);
    wait_drained();
    set_registers(32'd1, 16'd1, 8'd1);
    send_guess(32'sh0001_0000);
    wait_drained();
  endtask

  // Zero limit, zero tolerance, a zero radicand (which only halves), and a
  // write to an unmapped index that must leave every register as it was.
  task automatic test_special_cases();
    set_registers(RADICAND_RST, TOLERANCE_RST, 8'd0);
    send_guess(32'sh0000_3039);
    wait_drained();
    set_registers(RADICAND_RST, 16'd0, 8'd12);
    send_guess(32'sh0003_0000);
    wait_drained();
    set_registers(32'd0, TOLERANCE_RST, LIMIT_RST);
    send_guess(32'sh4000_0000);
    send_guess(-32'sh0123_4567);
    wait_drained();
    set_registers(32'h0009_0000, 16'd3, 8'd40);
    write_register(REG_NONE, 32'hFFFF_FFFF);
    send_guess(32'sh0001_0000);
    wait_drained();
  endtask

  // Random phases. Each phase picks new register values and then sends a
  // batch of guesses. Limits stay small except in one phase, so that items
  // that never converge do not run for too long. Idle gaps stop in the last
  // phases, so that items there arrive back to back.
  task automatic test_random_phases();
    logic [RADICAND_W-1:0]      radicand;
    logic [CFG_DATA_W-1:0]      tol_word;
    logic [LIMIT_W-1:0]         limit;
    logic signed [GUESS_W-1:0]  guess;
    int unsigned                pick;
    for (int phase = 0; phase < 8; phase++) begin
      gaps_on = (phase < 6);
      wait_drained();
      radicand = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 32'h0100_0000);
      // The upper bits of the tolerance write carry noise that must be dropped.
      tol_word = $urandom;
      tol_word[TOLERANCE_W-1:0] = ($urandom_range(0, 3) == 0)
                                  ? TOLERANCE_W'($urandom_range(1, 65535))
                                  : TOLERANCE_W'($urandom_range(1, 16));
      limit = (phase == 2) ? 8'd255 : LIMIT_W'($urandom_range(1, 48));
      write_register(REG_RADICAND, radicand);
      write_register(REG_TOLERANCE, tol_word);
      write_register(REG_LIMIT, {8'($urandom_range(0, 255)), 16'd0, limit});
      for (int n = 0; n < 13; n++) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0, 1: guess = $urandom;
          2: guess = $urandom_range(1, 32'h0010_0000);
          3: guess = -$signed({1'b0, 31'($urandom_range(1, 32'h0010_0000))});
          default: begin
            case ($urandom_range(0, 4))
              0: guess = 32'sh0;
              1: guess = 32'sh1;
              2: guess = -32'sh1;
              3: guess = 32'sh7FFF_FFFF;
              default: guess = 32'sh8000_0000;
            endcase
          end
        endcase
        send_guess(guess);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_RADICAND;
    cfg_data_i      = '0;
    start           = 1'b0;
    initial_guess_i = '0;
    cur_radicand    = RADICAND_RST;
    cur_tolerance   = TOLERANCE_RST;
    cur_limit       = LIMIT_RST;
    mismatch_count  = 0;
    gaps_on         = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_registers();
    test_zero_divisor();
    test_register_extremes();
    test_special_cases();
    test_random_phases();

    // Let the last results drain, then give any stray strobe time to show up.
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("heron_square_root_iteration: match");
    end else begin
      $display("heron_square_root_iteration: mismatch");
    end
    $finish;
  end

endmodule
